// ===== hdl/dct8_pkg.sv =====
// ----------------------------------------------------------------------------
// dct8_pkg
// Shared constants and helpers for the pipelined 8-point DCT: the rotation
// and scaling constants at 24 fractional bits and their rounding to the
// coefficient precision used in the datapath.
// ----------------------------------------------------------------------------
package dct8_pkg;

    // Number of points per transform and fixed result field width
    localparam int NUM_PTS = 8;
    localparam int COEF_W  = 16;

    // Master precision of the constant table
    localparam int KQ_BITS = 24;

    // Rotation constants: cos, sin-cos, -sin-cos for pi/16, 3pi/16,
    // and sqrt(2)-scaled for 6pi/16; plus sqrt(2) itself
    localparam logic signed [63:0] K_C1      = 64'sd16454846;
    localparam logic signed [63:0] K_S1MC1   = -64'sd13181774;
    localparam logic signed [63:0] K_NS1MC1  = -64'sd19727919;
    localparam logic signed [63:0] K_C3      = 64'sd13949745;
    localparam logic signed [63:0] K_S3MC3   = -64'sd4628823;
    localparam logic signed [63:0] K_NS3MC3  = -64'sd23270667;
    localparam logic signed [63:0] K_R2C6    = 64'sd9079764;
    localparam logic signed [63:0] K_R2S6MC  = 64'sd12840725;
    localparam logic signed [63:0] K_NR2S6MC = -64'sd31000253;
    localparam logic signed [63:0] K_SQRT2   = 64'sd23726566;

    // Reduce a 24-fraction-bit constant to frac bits, round half up
    function automatic logic signed [63:0] kround(input logic signed [63:0] k24,
                                                  input int unsigned frac);
        logic [5:0] sh;
        sh = 6'(KQ_BITS - frac);
        return (k24 + (64'sd1 <<< (sh - 6'd1))) >>> sh;
    endfunction

endpackage

// ===== hdl/dct_8point_fast.sv =====
// ----------------------------------------------------------------------------
// dct_8point_fast
// Unnormalized 8-point DCT-II on the Loeffler flow graph, six-stage pipeline.
// ----------------------------------------------------------------------------
//  channel  | direction | signals                          | content
//  ---------+-----------+----------------------------------+---------------------
//  slave    | in        | i_s_tvalid o_s_tready i_s_tdata  | eight samples
//  master   | out       | o_m_tvalid i_m_tready o_m_tdata  | eight coefficients
//
//  One vector enters per cycle unless stalled. The stages are butterfly,
//  rotation multiply, rotation sum, butterfly, sqrt(2) multiply and round.
//  Each stage holds its own valid bit and advances when the next stage is
//  free, so bubbles collapse and a stall neither drops nor repeats.
//  i_rst_n (synchronous, active low) clears the valid bits only.
// ----------------------------------------------------------------------------
module dct_8point_fast #(
    parameter int SAMPLE_BITS     = 9,
    parameter int CONST_FRAC_BITS = 14,
    parameter int OUT_FRAC_BITS   = 3
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    // slave side
    input  logic                                          i_s_tvalid,
    output logic                                          o_s_tready,
    // tdata: sample_0 .. sample_7, SAMPLE_BITS each, from the lowest bit up
    input  logic [dct8_pkg::NUM_PTS*SAMPLE_BITS-1:0]      i_s_tdata,
    // master side
    output logic                                          o_m_tvalid,
    input  logic                                          i_m_tready,
    // tdata: coef_0 .. coef_7, 16 bits each, from the lowest bit up
    output logic [dct8_pkg::NUM_PTS*dct8_pkg::COEF_W-1:0] o_m_tdata
);

    localparam int S   = SAMPLE_BITS;
    localparam int F   = CONST_FRAC_BITS;
    localparam int OW  = dct8_pkg::COEF_W;
    localparam int AW  = S + 1;              // first butterfly
    localparam int BW  = S + 2;              // second butterfly
    localparam int EW  = S + 3;              // DC / Nyquist terms
    localparam int KW  = F + 3;              // rounded constants
    localparam int PW  = KW + BW + 1;        // raw rotation products
    localparam int RW  = S + F + 8;          // rotation outputs, F fraction bits
    localparam int DW  = S + 2 * F + 8;      // sqrt(2) products, 2F fraction bits
    localparam int SH1 = F - OUT_FRAC_BITS;
    localparam int SH2 = 2 * F - OUT_FRAC_BITS;

    localparam logic signed [KW-1:0] C_C1 =
        KW'(dct8_pkg::kround(dct8_pkg::K_C1, F));
    localparam logic signed [KW-1:0] C_S1MC1 =
        KW'(dct8_pkg::kround(dct8_pkg::K_S1MC1, F));
    localparam logic signed [KW-1:0] C_NS1MC1 =
        KW'(dct8_pkg::kround(dct8_pkg::K_NS1MC1, F));
    localparam logic signed [KW-1:0] C_C3 =
        KW'(dct8_pkg::kround(dct8_pkg::K_C3, F));
    localparam logic signed [KW-1:0] C_S3MC3 =
        KW'(dct8_pkg::kround(dct8_pkg::K_S3MC3, F));
    localparam logic signed [KW-1:0] C_NS3MC3 =
        KW'(dct8_pkg::kround(dct8_pkg::K_NS3MC3, F));
    localparam logic signed [KW-1:0] C_R2C6 =
        KW'(dct8_pkg::kround(dct8_pkg::K_R2C6, F));
    localparam logic signed [KW-1:0] C_R2S6MC =
        KW'(dct8_pkg::kround(dct8_pkg::K_R2S6MC, F));
    localparam logic signed [KW-1:0] C_NR2S6MC =
        KW'(dct8_pkg::kround(dct8_pkg::K_NR2S6MC, F));
    localparam logic signed [KW-1:0] C_SQRT2 =
        KW'(dct8_pkg::kround(dct8_pkg::K_SQRT2, F));

    // ------------------------------------------------------------------
    // Stage control
    // ------------------------------------------------------------------
    logic [6:1] r_v;
    logic [6:1] w_en;

    // Each stage loads when empty or when its successor loads
    always_comb begin
        w_en[6] = !r_v[6] || i_m_tready;
        for (int k = 5; k >= 1; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_s_tready = w_en[1];
    assign o_m_tvalid = r_v[6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[1]) r_v[1] <= i_s_tvalid;
            for (int k = 2; k <= 6; k++) begin
                if (w_en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: first add-subtract butterfly
    // ------------------------------------------------------------------
    logic signed [S-1:0]  w_x [0:7];
    logic signed [AW-1:0] n1_a [0:7];
    logic signed [AW-1:0] r1_a [0:7];

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w_x[i] = i_s_tdata[i*S +: S];
        end
        for (int i = 0; i < 4; i++) begin
            n1_a[i]     = AW'(w_x[i]) + AW'(w_x[7-i]);
            n1_a[7 - i] = AW'(w_x[i]) - AW'(w_x[7-i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) r1_a <= n1_a;
    end

    // ------------------------------------------------------------------
    // Stage 2: even butterfly, odd-part rotation products
    // ------------------------------------------------------------------
    logic signed [BW-1:0] n2_b [0:3];
    logic signed [BW-1:0] w2_s74, w2_s65;
    logic signed [PW-1:0] n2_z1, n2_p4, n2_p7, n2_z2, n2_p5, n2_p6;
    logic signed [BW-1:0] r2_b [0:3];
    logic signed [PW-1:0] r2_z1, r2_p4, r2_p7, r2_z2, r2_p5, r2_p6;

    always_comb begin
        n2_b[0] = BW'(r1_a[0]) + BW'(r1_a[3]);
        n2_b[1] = BW'(r1_a[1]) + BW'(r1_a[2]);
        n2_b[2] = BW'(r1_a[1]) - BW'(r1_a[2]);
        n2_b[3] = BW'(r1_a[0]) - BW'(r1_a[3]);
        w2_s74  = BW'(r1_a[7]) + BW'(r1_a[4]);
        w2_s65  = BW'(r1_a[6]) + BW'(r1_a[5]);
        n2_z1   = PW'(C_C3)     * PW'(w2_s74);
        n2_p4   = PW'(C_S3MC3)  * PW'(r1_a[7]);
        n2_p7   = PW'(C_NS3MC3) * PW'(r1_a[4]);
        n2_z2   = PW'(C_C1)     * PW'(w2_s65);
        n2_p5   = PW'(C_S1MC1)  * PW'(r1_a[6]);
        n2_p6   = PW'(C_NS1MC1) * PW'(r1_a[5]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r2_b  <= n2_b;
            r2_z1 <= n2_z1;
            r2_p4 <= n2_p4;
            r2_p7 <= n2_p7;
            r2_z2 <= n2_z2;
            r2_p5 <= n2_p5;
            r2_p6 <= n2_p6;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: finish odd rotations, DC/Nyquist, even rotation products
    // ------------------------------------------------------------------
    logic signed [BW:0]   w3_s32;
    logic signed [RW-1:0] r3_b4, r3_b5, r3_b6, r3_b7;
    logic signed [EW-1:0] r3_e0, r3_e1;
    logic signed [PW-1:0] r3_z3, r3_q2, r3_q3;

    assign w3_s32 = (BW + 1)'(r2_b[3]) + (BW + 1)'(r2_b[2]);

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r3_b4 <= RW'(r2_p4) + RW'(r2_z1);
            r3_b7 <= RW'(r2_p7) + RW'(r2_z1);
            r3_b5 <= RW'(r2_p5) + RW'(r2_z2);
            r3_b6 <= RW'(r2_p6) + RW'(r2_z2);
            r3_e0 <= EW'(r2_b[0]) + EW'(r2_b[1]);
            r3_e1 <= EW'(r2_b[0]) - EW'(r2_b[1]);
            r3_z3 <= PW'(C_R2C6)    * PW'(w3_s32);
            r3_q2 <= PW'(C_R2S6MC)  * PW'(r2_b[3]);
            r3_q3 <= PW'(C_NR2S6MC) * PW'(r2_b[2]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: odd butterfly, finish even rotation
    // ------------------------------------------------------------------
    logic signed [RW-1:0] r4_c4, r4_c5, r4_c6, r4_c7, r4_e2, r4_e3;
    logic signed [EW-1:0] r4_e0, r4_e1;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r4_c4 <= r3_b4 + r3_b6;
            r4_c5 <= r3_b7 - r3_b5;
            r4_c6 <= r3_b4 - r3_b6;
            r4_c7 <= r3_b7 + r3_b5;
            r4_e2 <= RW'(r3_q2) + RW'(r3_z3);
            r4_e3 <= RW'(r3_q3) + RW'(r3_z3);
            r4_e0 <= r3_e0;
            r4_e1 <= r3_e1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: last odd butterfly, sqrt(2) scalings
    // ------------------------------------------------------------------
    logic signed [RW-1:0] r5_d4, r5_d7, r5_e2, r5_e3;
    logic signed [DW-1:0] r5_d5, r5_d6;
    logic signed [EW-1:0] r5_e0, r5_e1;

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r5_d4 <= r4_c7 - r4_c4;
            r5_d7 <= r4_c7 + r4_c4;
            r5_d5 <= DW'(r4_c5) * DW'(C_SQRT2);
            r5_d6 <= DW'(r4_c6) * DW'(C_SQRT2);
            r5_e2 <= r4_e2;
            r5_e3 <= r4_e3;
            r5_e0 <= r4_e0;
            r5_e1 <= r4_e1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: round to output precision, output register
    // ------------------------------------------------------------------
    localparam logic signed [RW-1:0] HALF1 = RW'(1) <<< (SH1 - 1);
    localparam logic signed [DW-1:0] HALF2 = DW'(1) <<< (SH2 - 1);

    logic signed [RW-1:0] w6_dc, w6_ny, w6_r1, w6_r2, w6_r6, w6_r7;
    logic signed [DW-1:0] w6_r3, w6_r5;
    logic [OW-1:0]        n6_coef [0:7];
    logic [OW-1:0]        r6_coef [0:7];

    always_comb begin
        w6_dc = RW'(r5_e0) <<< OUT_FRAC_BITS;
        w6_ny = RW'(r5_e1) <<< OUT_FRAC_BITS;
        w6_r1 = (r5_d7 + HALF1) >>> SH1;
        w6_r2 = (r5_e2 + HALF1) >>> SH1;
        w6_r6 = (r5_e3 + HALF1) >>> SH1;
        w6_r7 = (r5_d4 + HALF1) >>> SH1;
        w6_r3 = (r5_d5 + HALF2) >>> SH2;
        w6_r5 = (r5_d6 + HALF2) >>> SH2;
        n6_coef[0] = w6_dc[OW-1:0];
        n6_coef[1] = w6_r1[OW-1:0];
        n6_coef[2] = w6_r2[OW-1:0];
        n6_coef[3] = w6_r3[OW-1:0];
        n6_coef[4] = w6_ny[OW-1:0];
        n6_coef[5] = w6_r5[OW-1:0];
        n6_coef[6] = w6_r6[OW-1:0];
        n6_coef[7] = w6_r7[OW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en[6]) r6_coef <= n6_coef;
    end

    // Pack coefficients, coef_0 lowest
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            o_m_tdata[i*OW +: OW] = r6_coef[i];
        end
    end

endmodule
